[hdl/gpio_prb_pkg.sv]
// Shared constants, register index codes and helper functions for the GPIO register block.
package gpio_prb_pkg;

  localparam int NUM_PINS = 54;
  localparam int PINS_PAD = 64;
  localparam int FSEL_REGS = 6;
  localparam int FSEL_PER_REG = 10;
  localparam int FSEL_BITS = 3;
  localparam int FSEL_W = FSEL_PER_REG * FSEL_BITS;
  localparam int PULL_W = 2;
  localparam int HIGH_W = 22;

  typedef logic [FSEL_W-1:0] fsel_word_t;
  typedef logic [NUM_PINS-1:0] pin_vec_t;
  typedef logic [PULL_W-1:0] pull_t;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [3:0] REG_FSEL0 = 4'd0;
  localparam logic [3:0] REG_FSEL5 = 4'd5;
  localparam logic [3:0] REG_SET_LO = 4'd6;
  localparam logic [3:0] REG_SET_HI = 4'd7;
  localparam logic [3:0] REG_CLR_LO = 4'd8;
  localparam logic [3:0] REG_CLR_HI = 4'd9;
  localparam logic [3:0] REG_LEV_LO = 4'd10;
  localparam logic [3:0] REG_LEV_HI = 4'd11;
  localparam logic [3:0] REG_PULL = 4'd12;
  localparam logic [3:0] REG_PCLK_LO = 4'd13;
  localparam logic [3:0] REG_PCLK_HI = 4'd14;

  // Bits of one function-select register that belong to existing pins.
  function automatic fsel_word_t fsel_mask(input logic [2:0] r);
    fsel_word_t m;
    m = '0;
    for (int k = 0; k < FSEL_PER_REG; k++) begin
      if (int'(r) * FSEL_PER_REG + k < NUM_PINS) begin
        m[k*FSEL_BITS +: FSEL_BITS] = '1;
      end
    end
    return m;
  endfunction

  // Place a 32-bit word on the lower or upper half of the pin vector.
  function automatic pin_vec_t word_to_pins(input logic [31:0] w, input logic half);
    logic [PINS_PAD-1:0] v;
    v = half ? {w, 32'h0} : {32'h0, w};
    return v[NUM_PINS-1:0];
  endfunction

endpackage

[hdl/gpio_pin_register_block.sv]
// GPIO register block: function select, set/clear output latch, level readback and pull control.
// A transaction is taken into the input register and its result is held in the result register.
// Throughput: one transaction per cycle unless out_stall holds a result; the access executes
// between the input register and the result register, where all register state is updated.
// Reset (rst_n low, synchronous) empties both stages and clears function select,
// the output latch, pull control and every pin's pull state to zero.
module gpio_pin_register_block (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_access_error,
  output logic [31:0] out_pins_low,
  output logic [gpio_prb_pkg::HIGH_W-1:0] out_pins_high
);
  import gpio_prb_pkg::*;

  // Input stage.
  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [3:0]  s1_idx_r;
  logic [31:0] s1_data_r;

  // Register state.
  fsel_word_t fsel_r [FSEL_REGS];
  pin_vec_t   latch_r;
  pin_vec_t   latch_nxt;
  pull_t      pull_ctl_r;
  pull_t      pull_state_r [NUM_PINS];

  // Result stage.
  logic        out_valid_r;
  logic [31:0] rd_r;
  logic        err_r;
  logic [31:0] lo_r;
  logic [HIGH_W-1:0] hi_r;

  logic        out_free;
  logic        exec;
  logic        accept;
  logic        wr;
  logic [31:0] rd_nxt;
  logic        err_nxt;
  logic        fsel_we;
  logic        pull_we;
  logic        pclk_we;
  pin_vec_t    pclk_hits;
  logic [PINS_PAD-1:0] latch_pad;

  assign out_free = !out_valid_r || !out_stall;
  assign exec     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign wr       = (s1_kind_r == KIND_WRITE);

  assign latch_pad = PINS_PAD'(latch_r);
  assign pclk_hits = word_to_pins(s1_data_r, s1_idx_r == REG_PCLK_HI);

  always_comb begin
    rd_nxt    = '0;
    err_nxt   = 1'b0;
    latch_nxt = latch_r;
    fsel_we   = 1'b0;
    pull_we   = 1'b0;
    pclk_we   = 1'b0;
    unique case (s1_idx_r) inside
      [REG_FSEL0:REG_FSEL5]: begin
        if (wr) begin
          fsel_we = 1'b1;
        end else begin
          rd_nxt = 32'(fsel_r[s1_idx_r[2:0]]);
        end
      end
      REG_SET_LO, REG_SET_HI: begin
        if (wr) begin
          latch_nxt = latch_r | word_to_pins(s1_data_r, s1_idx_r == REG_SET_HI);
        end
      end
      REG_CLR_LO, REG_CLR_HI: begin
        if (wr) begin
          latch_nxt = latch_r & ~word_to_pins(s1_data_r, s1_idx_r == REG_CLR_HI);
        end
      end
      REG_LEV_LO: begin
        if (!wr) begin
          rd_nxt = latch_pad[31:0];
        end
      end
      REG_LEV_HI: begin
        if (!wr) begin
          rd_nxt = latch_pad[63:32];
        end
      end
      REG_PULL: begin
        if (wr) begin
          pull_we = 1'b1;
        end else begin
          rd_nxt = 32'(pull_ctl_r);
        end
      end
      REG_PCLK_LO, REG_PCLK_HI: begin
        pclk_we = wr;
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (exec) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_kind;
      s1_idx_r  <= in_reg_index;
      s1_data_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < FSEL_REGS; r++) begin
        fsel_r[r] <= '0;
      end
      latch_r    <= '0;
      pull_ctl_r <= '0;
      for (int p = 0; p < NUM_PINS; p++) begin
        pull_state_r[p] <= '0;
      end
    end else if (exec) begin
      latch_r <= latch_nxt;
      if (fsel_we) begin
        fsel_r[s1_idx_r[2:0]] <= s1_data_r[FSEL_W-1:0] & fsel_mask(s1_idx_r[2:0]);
      end
      if (pull_we) begin
        pull_ctl_r <= s1_data_r[PULL_W-1:0];
      end
      if (pclk_we) begin
        for (int p = 0; p < NUM_PINS; p++) begin
          if (pclk_hits[p]) begin
            pull_state_r[p] <= pull_ctl_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The pin outputs show the latch as it stands after this transaction.
  logic [PINS_PAD-1:0] latch_nxt_pad;
  assign latch_nxt_pad = PINS_PAD'(latch_nxt);

  always_ff @(posedge clk) begin
    if (exec) begin
      rd_r  <= wr ? 32'h0 : rd_nxt;
      err_r <= err_nxt;
      lo_r  <= latch_nxt_pad[31:0];
      hi_r  <= latch_nxt_pad[32 +: HIGH_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rd_r;
  assign out_access_error = err_r;
  assign out_pins_low     = lo_r;
  assign out_pins_high    = hi_r;

endmodule
